### rtl/core/circular_array_list_core_macros.svh
// Assertion macros for the circular array list core.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CIRCULAR_ARRAY_LIST_CORE_MACROS_SVH
`define CIRCULAR_ARRAY_LIST_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circular_array_list_core: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define CAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circular_array_list_core: next-cycle check failed");

`endif

### rtl/core/cal_pkg.sv
// Package for the circular array list core.
// Operation codes and the shift control type shared by the cells and top level.
`timescale 1ns / 1ps
`default_nettype none

package cal_pkg;

  typedef enum logic [2:0] {
    OP_FRONT     = 3'd0,
    OP_APPEND    = 3'd1,
    OP_INSERT_AT = 3'd2,
    OP_DELETE_AT = 3'd3,
    OP_READ_AT   = 3'd4,
    OP_FIND      = 3'd5,
    OP_CLEAR     = 3'd6
  } cal_op_e;

  typedef struct packed {
    logic ins;
    logic del;
  } cal_shift_t;

endpackage

`default_nettype wire

### rtl/core/cal_cell.sv
// One storage cell of the list: holds the word at a fixed logical index.
// Shifts toward higher or lower neighbors on insert and delete; depends on cal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cal_cell #(
  parameter int Idx      = 0,
  parameter int PosW     = 4,
  parameter int WordBits = 32
) (
  input  wire logic                  clk_i,
  input  wire cal_pkg::cal_shift_t   shift_i,
  input  wire logic [PosW-1:0]       pos_i,
  input  wire logic [WordBits-1:0]   word_i,
  input  wire logic [WordBits-1:0]   left_i,
  input  wire logic [WordBits-1:0]   right_i,
  output logic      [WordBits-1:0]   data_o,
  output logic                       match_o
);
  import cal_pkg::*;

  localparam logic [PosW-1:0] IdxV = PosW'(Idx);

  logic [WordBits-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (shift_i.ins && (IdxV > pos_i)) begin
      data_d = left_i;
    end else if (shift_i.ins && (IdxV == pos_i)) begin
      data_d = word_i;
    end else if (shift_i.del && (IdxV >= pos_i)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == word_i);

endmodule

`default_nettype wire

### rtl/core/cal_find.sv
// Highest-index match encoder over the cell compare flags.
// Gates flags beyond the entry count; returns all ones when nothing matches.
`timescale 1ns / 1ps
`default_nettype none

module cal_find #(
  parameter int Capacity = 16,
  parameter int CntW     = 5,
  parameter int FoundW   = 5
) (
  input  wire logic [Capacity-1:0] match_i,
  input  wire logic [CntW-1:0]     count_i,
  output logic      [FoundW-1:0]   found_o
);
  import cal_pkg::*;

  always_comb begin
    found_o = '1;
    for (int i = 0; i < Capacity; i++) begin
      if (match_i[i] && (CntW'(i) < count_i)) begin
        found_o = FoundW'(i);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/circular_array_list_core.sv
// Circular array list core: ordered list of words kept in a chain of cells.
// Depends on cal_pkg, cal_cell, cal_find and the assertion macro header.
//
// Usage:
//   Request channel: in_valid_i / in_stall_o with operation_i, position_i, word_in_i.
//   Result channel:  out_valid_o / out_stall_i with ok_o, word_out_o,
//   found_index_o, entry_count_o. A transfer happens when valid is high and
//   stall is low.
//   Every request gives exactly one result, registered in the cycle after the
//   request is taken. Cells sit in logical order, so inserts and deletes shift
//   the whole chain as the result is registered and find compares all cells at once.
//   Throughput is one request per cycle; the result register is the only
//   buffer, so in_stall_o rises while a result waits and out_stall_i is high.
//   Reset clears the entry count and the result valid; cell contents are
//   undefined until written and are never read before that.
//   Rejected requests (full list, index out of range, unused code) give
//   ok_o = 0, word_out_o = 0 and leave the list unchanged.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_array_list_core_macros.svh"

module circular_array_list_core #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32,
  localparam int PosW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CntW     = $clog2(CAPACITY + 1),
  localparam int FoundW   = PosW + 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [2:0]                 operation_i,
  input  wire logic [PosW-1:0]            position_i,
  input  wire logic [WORD_BITS-1:0]       word_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            ok_o,
  output logic      [WORD_BITS-1:0]       word_out_o,
  output logic signed [FoundW-1:0]        found_index_o,
  output logic      [CntW-1:0]            entry_count_o
);
  import cal_pkg::*;

  logic                 accept;
  logic                 full;
  logic                 pos_ok;
  logic [CntW-1:0]      count_q, count_d;
  cal_shift_t           shift;
  logic [PosW-1:0]      shift_pos;
  logic [WORD_BITS-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]  match;
  logic [FoundW-1:0]    find_idx;

  logic                 ok_d;
  logic [WORD_BITS-1:0] word_d;
  logic [FoundW-1:0]    found_d;

  logic                 out_valid_q;
  logic                 ok_q;
  logic [WORD_BITS-1:0] word_q;
  logic [FoundW-1:0]    found_q;
  logic [CntW-1:0]      entry_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(CAPACITY));
  assign pos_ok     = (CntW'(position_i) < count_q);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    cal_cell #(
      .Idx      (g),
      .PosW     (PosW),
      .WordBits (WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .pos_i   (shift_pos),
      .word_i  (word_in_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

  cal_find #(
    .Capacity (CAPACITY),
    .CntW     (CntW),
    .FoundW   (FoundW)
  ) u_find (
    .match_i (match),
    .count_i (count_q),
    .found_o (find_idx)
  );

  always_comb begin
    count_d   = count_q;
    shift     = '0;
    shift_pos = position_i;
    ok_d      = 1'b0;
    word_d    = '0;
    found_d   = '1;
    case (operation_i)
      OP_FRONT: begin
        if (!full) begin
          shift.ins = 1'b1;
          shift_pos = '0;
          count_d   = count_q + CntW'(1);
          ok_d      = 1'b1;
        end
      end
      OP_APPEND: begin
        if (!full) begin
          shift.ins = 1'b1;
          shift_pos = count_q[PosW-1:0];
          count_d   = count_q + CntW'(1);
          ok_d      = 1'b1;
        end
      end
      OP_INSERT_AT: begin
        if (pos_ok && !full) begin
          shift.ins = 1'b1;
          count_d   = count_q + CntW'(1);
          ok_d      = 1'b1;
        end
      end
      OP_DELETE_AT: begin
        if (pos_ok) begin
          shift.del = 1'b1;
          word_d    = cell_data[position_i];
          count_d   = count_q - CntW'(1);
          ok_d      = 1'b1;
        end
      end
      OP_READ_AT: begin
        if (pos_ok) begin
          word_d = cell_data[position_i];
          ok_d   = 1'b1;
        end
      end
      OP_FIND: begin
        found_d = find_idx;
        ok_d    = 1'b1;
      end
      OP_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (!accept) begin
      shift   = '0;
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok_d;
      word_q  <= word_d;
      found_q <= found_d;
      entry_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign word_out_o    = word_q;
  assign found_index_o = found_q;
  assign entry_count_o = entry_q;

  `CAL_ASSERT_NOW(a_count_range, 1'b1, count_q <= CntW'(CAPACITY))
  `CAL_ASSERT_NEXT(a_clear_empties, accept && (operation_i == OP_CLEAR), ok_q && (count_q == '0) && (entry_q == '0))
  `CAL_ASSERT_NEXT(a_reject_holds, accept && !ok_d, count_q == $past(count_q))
  `CAL_ASSERT_NOW(a_found_live, out_valid_q && !found_q[FoundW-1], ok_q && (CntW'(found_q[PosW-1:0]) < entry_q))

endmodule

`default_nettype wire
